// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the interpolator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/sti_pkg.sv -----
// Package: types, constants and codes of the sampled trace interpolator
package sti_pkg;
    localparam int GROUP_COUNT       = 8;
    localparam int SAMPLES_PER_GROUP = 256;
    localparam int GW   = 3;
    localparam int SW   = $clog2(SAMPLES_PER_GROUP);
    localparam int CW   = SW + 1;
    localparam int AW   = GW + SW;
    localparam int DEPTH = GROUP_COUNT * SAMPLES_PER_GROUP;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY_ONE = 2'd2,
        OP_QUERY_ALL = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         group;
        logic [31:0]        sample_time;
        logic signed [31:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         group_out;
        logic               found;
        logic signed [31:0] value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic               last;
    } out_item_t;

    // query handed from front to back
    typedef struct packed {
        logic [GW-1:0]      group;
        logic [CW-1:0]      count;
        logic [31:0]        qtime;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic               found;
        logic               last;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_RD_FIRST, BK_WAIT_FIRST, BK_RD_LAST, BK_WAIT_LAST,
        BK_SCAN, BK_SCAN_WAIT, BK_RD_PRED, BK_WAIT_PRED, BK_MUL, BK_DIV, BK_SUM, BK_EMIT
    } bk_state_t;
endpackage

// ----- hw/rtl/sti_ram.sv -----
// Generic single-port-write, single-read RAM with registered read
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/sti_front.sv -----
// Front end: accepts items, keeps group bookkeeping, queues queries
module sti_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sti_pkg::in_item_t in_item,
    output logic              wr_en,
    output logic [sti_pkg::AW-1:0] wr_addr,
    output logic              job_valid,
    output sti_pkg::job_t     job,
    input  logic              job_take,
    input  logic              back_idle
);
    import sti_pkg::*;

    logic [CW-1:0]      fill_reg [GROUP_COUNT];
    logic signed [31:0] low_reg  [GROUP_COUNT];
    logic signed [31:0] high_reg [GROUP_COUNT];
    job_t               q_reg [QDEPTH];
    logic [1:0]         cnt_reg, cnt_next;
    logic               all_reg;
    logic [GW-1:0]      all_g_reg;
    logic [31:0]        all_t_reg;
    logic               accept, push, full, clear_hold;
    logic               push_slot;
    job_t               push_job;
    logic [GW-1:0]      pg;
    op_t                op;

    assign op     = op_t'(in_item.opcode);
    assign full   = (cnt_reg == 2'(QDEPTH));
    // a clear waits until queued queries are done, so later appends
    // cannot overwrite samples that a pending query still reads
    assign clear_hold = (op == OP_CLEAR) && (job_valid || !back_idle);
    assign busy   = all_reg || full || clear_hold;
    assign accept = start && !busy;
    assign wr_en  = accept && op == OP_APPEND &&
                    fill_reg[in_item.group] < CW'(SAMPLES_PER_GROUP);
    assign wr_addr = {in_item.group, fill_reg[in_item.group][SW-1:0]};

    // job source: sweep of all groups or a single query
    always_comb
    begin
        pg = all_reg ? all_g_reg : in_item.group;
        push = (all_reg && !full) || (accept && op == OP_QUERY_ONE);
        push_job.group      = pg;
        push_job.count      = fill_reg[pg];
        push_job.qtime      = all_reg ? all_t_reg : in_item.sample_time;
        push_job.found      = fill_reg[pg] != '0;
        push_job.range_low  = low_reg[pg];
        push_job.range_high = high_reg[pg];
        push_job.last       = all_reg ? (all_g_reg == GW'(GROUP_COUNT - 1)) : 1'b1;
    end

    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[0];
    assign push_slot = 1'(cnt_reg - 2'(job_take));

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(job_take);
    end

    // query queue
    always_ff @(posedge clk)
    begin
        if (push && push_slot == 1'b0)
        begin
            q_reg[0] <= push_job;
        end
        else if (job_take)
        begin
            q_reg[0] <= q_reg[1];
        end
        if (push && push_slot == 1'b1)
        begin
            q_reg[1] <= push_job;
        end
    end

    // group bookkeeping and sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            all_reg   <= 1'b0;
            all_g_reg <= '0;
            all_t_reg <= '0;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                fill_reg[g] <= '0;
                low_reg[g]  <= 32'sh7FFFFFFF;
                high_reg[g] <= 32'sh80000000;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (all_reg && !full)
            begin
                all_g_reg <= all_g_reg + 1'b1;
                if (all_g_reg == GW'(GROUP_COUNT - 1))
                begin
                    all_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                unique case (op)
                    OP_CLEAR:
                    begin
                        for (int g = 0; g < GROUP_COUNT; g++)
                        begin
                            fill_reg[g] <= '0;
                            low_reg[g]  <= 32'sh7FFFFFFF;
                            high_reg[g] <= 32'sh80000000;
                        end
                    end
                    OP_APPEND:
                    begin
                        if (wr_en)
                        begin
                            fill_reg[in_item.group] <= fill_reg[in_item.group] + 1'b1;
                            if (in_item.sample_value < low_reg[in_item.group])
                            begin
                                low_reg[in_item.group] <= in_item.sample_value;
                            end
                            if (in_item.sample_value > high_reg[in_item.group])
                            begin
                                high_reg[in_item.group] <= in_item.sample_value;
                            end
                        end
                    end
                    OP_QUERY_ONE:
                    begin
                    end
                    OP_QUERY_ALL:
                    begin
                        all_reg   <= 1'b1;
                        all_g_reg <= '0;
                        all_t_reg <= in_item.sample_time;
                    end
                endcase
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !push || job_take)
    `ASSERT_IMPL(a_take_valid, clk, rst_n, job_take, job_valid)
    `ASSERT_NEXT(a_sweep_busy, clk, rst_n, accept && op == OP_QUERY_ALL, busy)
endmodule

// ----- hw/rtl/sti_back.sv -----
// Back end: scans a group's samples and interpolates with a serial divider
module sti_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       time_step,
    input  logic              job_valid,
    input  sti_pkg::job_t     job,
    output logic              job_take,
    output logic              idle,
    output logic [sti_pkg::AW-1:0] rd_addr,
    input  logic [31:0]       rd_time,
    input  logic signed [31:0] rd_value,
    output logic              done,
    output sti_pkg::out_item_t result
);
    import sti_pkg::*;

    bk_state_t          state_reg, state_next;
    job_t               job_reg;
    logic [CW-1:0]      idx_reg, idx_next;
    logic signed [31:0] va_reg, vb_reg, res_reg;
    logic [31:0]        ta_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [64:0]        num_reg;     // dividend being shifted out
    logic [64:0]        rem_reg;
    logic [64:0]        quo_reg;
    logic [6:0]         bit_reg;
    logic [31:0]        step;
    logic [31:0]        elapsed;
    logic [65:0]        trial;
    logic signed [34:0] sum;
    logic [AW-1:0]      base_addr;

    assign idle    = (state_reg == BK_IDLE);
    assign step    = (time_step == '0) ? 32'd1 : time_step;
    assign elapsed = job_reg.qtime - ta_reg;
    assign trial   = {rem_reg, num_reg[64]} - {34'd0, step};
    assign base_addr = {job_reg.group, {SW{1'b0}}};
    assign sum = neg_reg ? 35'(va_reg) - $signed({2'b00, quo_reg[32:0]})
                         : 35'(va_reg) + $signed({2'b00, quo_reg[32:0]});

    // next state and read address
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        job_take   = 1'b0;
        rd_addr    = base_addr;
        done       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    state_next = job.found ? BK_RD_FIRST : BK_EMIT;
                end
            end
            BK_RD_FIRST: state_next = BK_WAIT_FIRST;
            BK_WAIT_FIRST:
            begin
                if (job_reg.qtime <= rd_time)
                begin
                    state_next = BK_EMIT;
                end
                else
                begin
                    state_next = BK_RD_LAST;
                end
            end
            BK_RD_LAST:
            begin
                rd_addr = base_addr | AW'(job_reg.count - 1'b1);
                state_next = BK_WAIT_LAST;
            end
            BK_WAIT_LAST:
            begin
                rd_addr = base_addr | AW'(job_reg.count - 1'b1);
                if (job_reg.qtime >= rd_time)
                begin
                    state_next = BK_EMIT;
                end
                else
                begin
                    idx_next = CW'(1);
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                rd_addr = base_addr | AW'(idx_reg);
                state_next = BK_SCAN_WAIT;
            end
            BK_SCAN_WAIT:
            begin
                rd_addr = base_addr | AW'(idx_reg);
                if (rd_time > job_reg.qtime)
                begin
                    state_next = BK_RD_PRED;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = BK_SCAN;
                end
            end
            BK_RD_PRED:
            begin
                rd_addr = base_addr | AW'(idx_reg - 1'b1);
                state_next = BK_WAIT_PRED;
            end
            BK_WAIT_PRED:
            begin
                rd_addr = base_addr | AW'(idx_reg - 1'b1);
                state_next = BK_MUL;
            end
            BK_MUL: state_next = BK_DIV;
            BK_DIV:
            begin
                if (bit_reg == 7'd0)
                begin
                    state_next = BK_SUM;
                end
            end
            BK_SUM: state_next = BK_EMIT;
            BK_EMIT:
            begin
                done = 1'b1;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                job_reg <= job;
                res_reg <= '0;
            end
            BK_WAIT_FIRST, BK_WAIT_LAST: res_reg <= rd_value;
            BK_SCAN_WAIT: vb_reg <= rd_value;
            BK_WAIT_PRED:
            begin
                ta_reg  <= rd_time;
                va_reg  <= rd_value;
                mag_reg <= (vb_reg >= rd_value) ? 33'(vb_reg) - 33'(rd_value)
                                                : 33'(rd_value) - 33'(vb_reg);
                neg_reg <= vb_reg < rd_value;
            end
            BK_MUL:
            begin
                num_reg <= 65'(mag_reg) * 65'(elapsed);
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 7'd64;
            end
            BK_DIV:
            begin
                num_reg <= num_reg << 1;
                if (!trial[65])
                begin
                    rem_reg <= trial[64:0];
                    quo_reg <= {quo_reg[63:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[63:0], num_reg[64]};
                    quo_reg <= {quo_reg[63:0], 1'b0};
                end
                bit_reg <= bit_reg - 1'b1;
            end
            BK_SUM:
            begin
                if (quo_reg > 65'h100000000)
                begin
                    res_reg <= neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
                end
                else if (sum > 35'sh7FFFFFFF)
                begin
                    res_reg <= 32'sh7FFFFFFF;
                end
                else if (sum < -35'sh80000000)
                begin
                    res_reg <= 32'sh80000000;
                end
                else
                begin
                    res_reg <= sum[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        result.group_out  = job_reg.group;
        result.found      = job_reg.found;
        result.value      = job_reg.found ? res_reg : '0;
        result.range_low  = job_reg.found ? job_reg.range_low : '0;
        result.range_high = job_reg.found ? job_reg.range_high : '0;
        result.last       = job_reg.last;
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_take_idle, clk, rst_n, job_take, state_reg == BK_IDLE)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, done, state_reg == BK_IDLE)
    `ASSERT_IMPL(a_scan_bound, clk, rst_n, state_reg == BK_SCAN, idx_reg < job_reg.count)
endmodule

// ----- hw/rtl/sampled_trace_interpolator_top.sv -----
// Top level of the sampled trace interpolator
// A clear waits (busy) until every queued query has finished. A query goes to a
// two-entry queue, registered, from which the back end takes it when idle. For an
// empty group the back end emits a not-found result; when the time is at or before
// the first sample it returns the first value, at or after the last one the last
// value, and otherwise it scans the samples for the first one later than the time,
// reads the one before it and interpolates in the serial divider. A query-all
// sweeps all 8 groups into the queue and holds busy until the sweep is queued.
// Results appear on done for one cycle each and cannot be held off. Setting
// time_step while items are in flight is not supported.
module sampled_trace_interpolator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sti_pkg::in_item_t   in_item,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output sti_pkg::out_item_t  result
);
    import sti_pkg::*;

    logic [31:0]        step_reg;
    logic               wr_en, job_valid, job_take, back_idle;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [31:0]        rd_time, rd_value;
    job_t               job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 32'h00010000;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_data;
        end
    end

    sti_front u_front (
        .clk, .rst_n, .start, .busy, .in_item,
        .wr_en, .wr_addr, .job_valid, .job, .job_take, .back_idle
    );

    sti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time_ram (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(in_item.sample_time),
        .raddr(rd_addr), .rdata(rd_time)
    );

    sti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(in_item.sample_value),
        .raddr(rd_addr), .rdata(rd_value)
    );

    sti_back u_back (
        .clk, .rst_n, .time_step(step_reg), .job_valid, .job, .job_take,
        .idle(back_idle), .rd_addr, .rd_time, .rd_value(signed'(rd_value)),
        .done, .result
    );
endmodule
